### hdl/ntsc_safe_color_limiter_defines.svh
// Assertion macros used by the color limiter top level.
`ifndef NTSC_SAFE_COLOR_LIMITER_DEFINES_SVH
`define NTSC_SAFE_COLOR_LIMITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NSCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/nscl_pkg.sv
// Shared types, constants and helpers of the composite-safe color limiter.
package nscl_pkg;

  localparam int FRAC_BITS   = 14;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int SQRT_STAGES = 17;
  localparam int DIV_STAGES  = 17;

  localparam logic CFG_IDX_EXC = 1'b0;
  localparam logic CFG_IDX_EPS = 1'b1;

  // Luma and chroma rotation coefficients, scaled by 2^16.
  localparam logic signed [18:0] C_YR = 19'sd19595;
  localparam logic signed [18:0] C_YG = 19'sd38470;
  localparam logic signed [18:0] C_YB = 19'sd7471;
  localparam logic signed [18:0] C_IR = 19'sd48203;
  localparam logic signed [18:0] C_IB = 19'sd17561;
  localparam logic signed [18:0] C_QR = 19'sd31303;
  localparam logic signed [18:0] C_QB = 19'sd27042;
  localparam logic signed [18:0] C_RI = 19'sd62652;
  localparam logic signed [18:0] C_RQ = 19'sd40632;
  localparam logic signed [18:0] C_GI = 19'sd17826;
  localparam logic signed [18:0] C_GQ = 19'sd42402;
  localparam logic signed [18:0] C_BI = 19'sd72614;
  localparam logic signed [18:0] C_BQ = 19'sd111739;

  typedef struct packed {
    logic signed [15:0] r;
    logic signed [15:0] g;
    logic signed [15:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t               pix;
    logic signed [16:0] y;
    logic signed [17:0] ci;
    logic signed [17:0] cq;
    logic [16:0]        c;
    logic [15:0]        target;
    logic signed [15:0] composite;
    logic               fix;
  } mid_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] res;
    if (v > 22'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

### hdl/ntsc_safe_color_limiter.sv
// Top level of the composite-safe color limiter: configuration and pipelines.
// A pushed word passes 25 front stages (17 of them for the square root), the
// middle queue, 21 back stages (17 for the two dividers) and the result queue.
// One word is accepted every cycle while pop keeps up. Reset clears the queues
// and valid bits and loads max_excursion to 1638 and margin_epsilon to 16.
`include "ntsc_safe_color_limiter_defines.svh"

module ntsc_safe_color_limiter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] red_in_i,
  input  logic signed [15:0] green_in_i,
  input  logic signed [15:0] blue_in_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] red_out_o,
  output logic signed [15:0] green_out_o,
  output logic signed [15:0] blue_out_o,
  output logic signed [15:0] excursion_o,
  output logic               adjusted_o
);
  import nscl_pkg::*;

  logic [11:0] exc_q;
  logic [10:0] eps_q;

  // Configuration registers; they are to be written only while the block is idle (a user rule, not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exc_q <= 12'd1638;
      eps_q <= 11'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_EXC: exc_q <= cfg_data_i;
        CFG_IDX_EPS: eps_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  rgb_t    pix_in;
  mid_t    fr_data, q_data;
  logic    fr_valid, q_push, q_pop;
  q_stat_t q_stat;

  assign pix_in.r = red_in_i;
  assign pix_in.g = green_in_i;
  assign pix_in.b = blue_in_i;

  // The front pipeline accepts a pixel whenever its last word can leave.
  nscl_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .pix_i    (pix_in),
    .exc_i    (exc_q),
    .eps_i    (eps_q),
    .q_full_i (q_stat.full),
    .valid_o  (fr_valid),
    .data_o   (fr_data)
  );

  assign q_push = fr_valid && !q_stat.full;

  nscl_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (fr_data),
    .pop_i  (q_pop),
    .data_o (q_data),
    .stat_o (q_stat)
  );

  // The back pipeline rescales chroma and rebuilds RGB; it stalls on its own.
  nscl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .excursion_o (excursion_o),
    .adjusted_o  (adjusted_o)
  );

  // A scaled word always carries a composite beyond one of the two limits.
  `NSCL_ASSERT_NOW(a_adj_exc, !empty && adjusted_o, (excursion_o > 16'sd16384) || (excursion_o < 16'sd0), "adjusted word without an excursion")
  // The front only holds off input when the middle queue is full.
  `NSCL_ASSERT_NOW(a_full_q, full, q_stat.full, "front stalled with room in the queue")
  // The back never pops an empty middle queue.
  `NSCL_ASSERT_NOW(a_pop_ok, q_pop, !q_stat.empty, "pop from an empty middle queue")

endmodule

### hdl/nscl_queue.sv
// Two-word queue that decouples the front and back pipelines.
module nscl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nscl_pkg::mid_t   data_i,
  input  logic             pop_i,
  output nscl_pkg::mid_t   data_o,
  output nscl_pkg::q_stat_t stat_o
);
  import nscl_pkg::*;

  mid_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign data_o       = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

### hdl/nscl_front.sv
// Front pipeline: luma, chroma rotation, chroma amplitude and classification.
module nscl_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  nscl_pkg::rgb_t pix_i,
  input  logic [11:0]    exc_i,
  input  logic [10:0]    eps_i,
  input  logic           q_full_i,
  output logic           valid_o,
  output nscl_pkg::mid_t data_o
);
  import nscl_pkg::*;

  localparam int NF = 6 + SQRT_STAGES + 2;

  typedef struct packed {
    rgb_t               pix;
    logic signed [16:0] y;
    logic signed [17:0] ci;
    logic signed [17:0] cq;
  } car_t;

  logic          en;
  logic [NF-1:0] vld_q;

  rgb_t               pix1_q, pix2_q, pix3_q;
  logic signed [33:0] pyr_q, pyg_q, pyb_q;
  logic signed [16:0] y2_q, y3_q;
  logic signed [17:0] dr2_q, db2_q;
  logic signed [35:0] pia_q, pib_q, pqa_q, pqb_q;
  car_t               car4_q, car5_q;
  logic signed [35:0] sqi_q, sqq_q;

  car_t        car_q  [SQRT_STAGES+1];
  logic [18:0] rem_q  [SQRT_STAGES+1];
  logic [16:0] root_q [SQRT_STAGES+1];
  logic [33:0] rad_q  [SQRT_STAGES+1];

  car_t        carr_q;
  logic [16:0] c_q;

  logic signed [33:0] ysum;
  logic signed [16:0] y2_d;
  logic signed [35:0] isum, qsum;

  // Front stalls only when its last stage holds a word the queue cannot take.
  assign en      = !(vld_q[NF-1] && q_full_i);
  assign full    = !en;
  assign valid_o = vld_q[NF-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NF-2:0], push};
    end
  end

  assign ysum = pyr_q + pyg_q + pyb_q + 34'sd32768;
  assign y2_d = 17'(ysum >>> 16);
  assign isum = pia_q - pib_q + 36'sd32768;
  assign qsum = pqa_q + pqb_q + 36'sd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix1_q <= pix_i;
      pyr_q  <= 34'(pix_i.r * C_YR);
      pyg_q  <= 34'(pix_i.g * C_YG);
      pyb_q  <= 34'(pix_i.b * C_YB);

      pix2_q <= pix1_q;
      y2_q   <= y2_d;
      dr2_q  <= 18'(pix1_q.r) - 18'(y2_d);
      db2_q  <= 18'(pix1_q.b) - 18'(y2_d);

      pix3_q <= pix2_q;
      y3_q   <= y2_q;
      pia_q  <= 36'(dr2_q * C_IR);
      pib_q  <= 36'(db2_q * C_IB);
      pqa_q  <= 36'(dr2_q * C_QR);
      pqb_q  <= 36'(db2_q * C_QB);

      car4_q.pix <= pix3_q;
      car4_q.y   <= y3_q;
      car4_q.ci  <= 18'(isum >>> 16);
      car4_q.cq  <= 18'(qsum >>> 16);

      car5_q <= car4_q;
      sqi_q  <= 36'(car4_q.ci * car4_q.ci);
      sqq_q  <= 36'(car4_q.cq * car4_q.cq);

      car_q[0]  <= car5_q;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= 34'(sqi_q + sqq_q);
    end
  end

  // One root bit per stage, restoring square root.
  for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
    logic [20:0] cat, trial;
    assign cat   = {rem_q[k-1], rad_q[k-1][33:32]};
    assign trial = {2'b00, root_q[k-1], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en) begin
        car_q[k] <= car_q[k-1];
        rad_q[k] <= {rad_q[k-1][31:0], 2'b00};
        if (cat >= trial) begin
          rem_q[k]  <= 19'(cat - trial);
          root_q[k] <= {root_q[k-1][15:0], 1'b1};
        end else begin
          rem_q[k]  <= 19'(cat);
          root_q[k] <= {root_q[k-1][15:0], 1'b0};
        end
      end
    end
  end

  logic signed [18:0] cs, hi, lo, lim_hi, lim_lo, t_hi, t_lo, tsel;
  logic               bad_hi, bad_lo;

  always_comb begin
    cs     = $signed({2'b00, c_q});
    hi     = 19'(carr_q.y) + cs;
    lo     = 19'(carr_q.y) - cs;
    lim_hi = 19'(ONE) + $signed({7'b0, exc_i});
    lim_lo = -$signed({7'b0, exc_i});
    t_hi   = lim_hi - $signed({8'b0, eps_i}) - 19'(carr_q.y);
    t_lo   = 19'(carr_q.y) + $signed({7'b0, exc_i}) - $signed({8'b0, eps_i});
    bad_hi = hi > lim_hi;
    bad_lo = !bad_hi && (lo < lim_lo);
    tsel   = bad_hi ? t_hi : t_lo;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      carr_q <= car_q[SQRT_STAGES];
      c_q    <= (rem_q[SQRT_STAGES] > {2'b00, root_q[SQRT_STAGES]})
                ? root_q[SQRT_STAGES] + 17'd1 : root_q[SQRT_STAGES];

      data_o.pix       <= carr_q.pix;
      data_o.y         <= carr_q.y;
      data_o.ci        <= carr_q.ci;
      data_o.cq        <= carr_q.cq;
      data_o.c         <= c_q;
      data_o.target    <= (tsel < 0) ? 16'd0 : tsel[15:0];
      data_o.composite <= bad_hi ? sat16(22'(hi)) : (bad_lo ? sat16(22'(lo)) : 16'sd0);
      data_o.fix       <= (bad_hi || bad_lo) && (c_q != 17'd0);
    end
  end

endmodule

### hdl/nscl_back.sv
// Back pipeline: chroma rescale by division, RGB rebuild and result queue.
module nscl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nscl_pkg::q_stat_t  q_stat_i,
  input  nscl_pkg::mid_t     q_data_i,
  output logic               q_pop_o,
  input  logic               pop,
  output logic               empty,
  output logic signed [15:0] red_out_o,
  output logic signed [15:0] green_out_o,
  output logic signed [15:0] blue_out_o,
  output logic signed [15:0] excursion_o,
  output logic               adjusted_o
);
  import nscl_pkg::*;

  localparam int NB = DIV_STAGES + 4;

  typedef struct packed {
    rgb_t               pix;
    logic signed [16:0] y;
    logic signed [15:0] composite;
    logic               fix;
    logic [16:0]        c;
    logic               neg_i;
    logic               neg_q;
  } bcar_t;

  typedef struct packed {
    rgb_t               pix;
    logic signed [15:0] excursion;
    logic               adjusted;
  } out_t;

  logic          en, out_full, out_push;
  logic [NB-1:0] vld_q;

  bcar_t       car0_q;
  logic [32:0] pri_q, prq_q;

  bcar_t       car_q  [DIV_STAGES+1];
  logic [33:0] remi_q [DIV_STAGES+1];
  logic [33:0] remq_q [DIV_STAGES+1];
  logic [16:0] qi_q   [DIV_STAGES+1];
  logic [16:0] qq_q   [DIV_STAGES+1];

  bcar_t              card_q, carp_q;
  logic signed [17:0] ni_q, nq_q;
  logic signed [36:0] pri2_q, prq2_q, pgi_q, pgq_q, pbi_q, pbq_q;

  logic [16:0] mi, mq;

  assign en      = !(vld_q[NB-1] && out_full);
  assign q_pop_o = en && !q_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NB-2:0], q_pop_o};
    end
  end

  assign mi = q_data_i.ci[17] ? 17'(-q_data_i.ci) : q_data_i.ci[16:0];
  assign mq = q_data_i.cq[17] ? 17'(-q_data_i.cq) : q_data_i.cq[16:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      car0_q.pix       <= q_data_i.pix;
      car0_q.y         <= q_data_i.y;
      car0_q.composite <= q_data_i.composite;
      car0_q.fix       <= q_data_i.fix;
      car0_q.c         <= q_data_i.c;
      car0_q.neg_i     <= q_data_i.ci[17];
      car0_q.neg_q     <= q_data_i.cq[17];
      pri_q            <= 33'(mi * q_data_i.target);
      prq_q            <= 33'(mq * q_data_i.target);

      // Add half the divisor so the quotient rounds to nearest.
      car_q[0]  <= car0_q;
      remi_q[0] <= 34'(pri_q) + 34'(car0_q.c >> 1);
      remq_q[0] <= 34'(prq_q) + 34'(car0_q.c >> 1);
      qi_q[0]   <= '0;
      qq_q[0]   <= '0;
    end
  end

  // One quotient bit per stage for each of the two restoring dividers.
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    localparam int J = DIV_STAGES - k;
    logic [33:0] dsh;
    assign dsh = 34'(car_q[k-1].c) << J;
    always_ff @(posedge clk_i) begin
      if (en) begin
        car_q[k] <= car_q[k-1];
        if (remi_q[k-1] >= dsh) begin
          remi_q[k] <= remi_q[k-1] - dsh;
          qi_q[k]   <= {qi_q[k-1][15:0], 1'b1};
        end else begin
          remi_q[k] <= remi_q[k-1];
          qi_q[k]   <= {qi_q[k-1][15:0], 1'b0};
        end
        if (remq_q[k-1] >= dsh) begin
          remq_q[k] <= remq_q[k-1] - dsh;
          qq_q[k]   <= {qq_q[k-1][15:0], 1'b1};
        end else begin
          remq_q[k] <= remq_q[k-1];
          qq_q[k]   <= {qq_q[k-1][15:0], 1'b0};
        end
      end
    end
  end

  logic signed [37:0] sr, sg, sb;
  out_t               res;

  always_comb begin
    sr = 38'(pri2_q) + 38'(prq2_q) + 38'sd32768;
    sg = 38'(pgi_q) + 38'(pgq_q) + 38'sd32768;
    sb = 38'(pbi_q) - 38'(pbq_q) + 38'sd32768;
    res.excursion = carp_q.composite;
    res.adjusted  = carp_q.fix;
    if (carp_q.fix) begin
      res.pix.r = sat16(22'(carp_q.y) + 22'(sr >>> 16));
      res.pix.g = sat16(22'(carp_q.y) - 22'(sg >>> 16));
      res.pix.b = sat16(22'(carp_q.y) - 22'(sb >>> 16));
    end else begin
      res.pix = carp_q.pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      card_q <= car_q[DIV_STAGES];
      ni_q   <= car_q[DIV_STAGES].neg_i ? -$signed({1'b0, qi_q[DIV_STAGES]})
                                        : $signed({1'b0, qi_q[DIV_STAGES]});
      nq_q   <= car_q[DIV_STAGES].neg_q ? -$signed({1'b0, qq_q[DIV_STAGES]})
                                        : $signed({1'b0, qq_q[DIV_STAGES]});

      carp_q <= card_q;
      pri2_q <= 37'(ni_q * C_RI);
      prq2_q <= 37'(nq_q * C_RQ);
      pgi_q  <= 37'(ni_q * C_GI);
      pgq_q  <= 37'(nq_q * C_GQ);
      pbi_q  <= 37'(ni_q * C_BI);
      pbq_q  <= 37'(nq_q * C_BQ);
    end
  end

  // Result queue of two words; the last stage pushes into it.
  out_t       oq_q [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       opop;

  assign out_full = (ocnt_q == 2'd2);
  assign empty    = (ocnt_q == 2'd0);
  assign out_push = en && vld_q[NB-1];
  assign opop     = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (out_push) begin
        owp_q <= ~owp_q;
      end
      if (opop) begin
        orp_q <= ~orp_q;
      end
      ocnt_q <= ocnt_q + 2'(out_push) - 2'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      oq_q[owp_q] <= res;
    end
  end

  assign red_out_o   = oq_q[orp_q].pix.r;
  assign green_out_o = oq_q[orp_q].pix.g;
  assign blue_out_o  = oq_q[orp_q].pix.b;
  assign excursion_o = oq_q[orp_q].excursion;
  assign adjusted_o  = oq_q[orp_q].adjusted;

endmodule
